// ----- design/ring_resource_arbiter_with_aging_assert.svh -----
// Assertion macros for the ring resource arbiter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RING_RESOURCE_ARBITER_WITH_AGING_ASSERT_SVH
`define RING_RESOURCE_ARBITER_WITH_AGING_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication under synchronous active-low reset.
`define RRA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rra: implication check failed");
// Next-cycle implication under synchronous active-low reset.
`define RRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rra: next-cycle check failed");
`else
`define RRA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define RRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/rra_pkg.sv -----
// Types and constants shared by the ring resource arbiter.
// No dependencies; imported by rra_cell and the top level.
`default_nettype none

package rra_pkg;

    localparam int AGENTS   = 5;
    localparam int AGE_BITS = 16;
    localparam int EVT_W    = 5;
    localparam int PRIO_W   = 16;

    typedef logic [AGE_BITS-1:0] t_age;

    typedef enum logic [1:0] {
        MODE_HUNGRY   = 2'd0,
        MODE_EATING   = 2'd1,
        MODE_THINKING = 2'd2,
        MODE_DONE     = 2'd3
    } t_mode;

    // scan token travelling from cell to cell
    typedef struct packed {
        logic tok;
        t_age top;
    } t_ctx;

    // resource update from a cell to its clockwise neighbor
    typedef struct packed {
        logic set;
        logic clr;
    } t_link;

    typedef struct packed {
        logic grant;
        logic release_done;
        logic eating;
        logic waiting;
    } t_status;

    typedef struct packed {
        logic [EVT_W-1:0] hunger_events;
        logic [EVT_W-1:0] finish_events;
    } t_in;

    typedef struct packed {
        logic [EVT_W-1:0]  grant_mask;
        logic [EVT_W-1:0]  release_mask;
        logic [EVT_W-1:0]  eating_mask;
        logic [EVT_W-1:0]  waiting_mask;
        logic [PRIO_W-1:0] top_priority_out;
    } t_out;

endpackage

`default_nettype wire

// ----- design/rra_cell.sv -----
// One agent cell of the arbiter ring: mode, age and the agent's own resource.
// Depends on rra_pkg and the assertion header.
`default_nettype none
`include "ring_resource_arbiter_with_aging_assert.svh"

module rra_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_hunger,
    input  wire logic             i_finish,
    input  wire rra_pkg::t_ctx    i_ctx,
    output rra_pkg::t_ctx         o_ctx,
    input  wire logic             i_nbr_busy,
    output logic                  o_busy,
    input  wire rra_pkg::t_link   i_link,
    output rra_pkg::t_link        o_link,
    output rra_pkg::t_status      o_status
);
    import rra_pkg::*;

    t_mode r_mode, n_mode;
    t_age  r_age, n_age;
    logic  r_busy, n_busy;
    logic  r_grant, n_grant;
    logic  r_rel, n_rel;
    t_ctx  r_ctx, n_ctx;

    always_comb begin
        n_mode   = r_mode;
        n_age    = r_age;
        n_busy   = r_busy;
        n_grant  = r_grant;
        n_rel    = r_rel;
        n_ctx    = i_ctx;
        o_link   = '0;
        if (i_load) begin
            n_grant = 1'b0;
            n_rel   = 1'b0;
            if (r_mode == MODE_THINKING && i_hunger) begin
                n_mode = MODE_HUNGRY;
            end else if (r_mode == MODE_EATING && i_finish) begin
                n_mode = MODE_DONE;
            end
        end else if (i_ctx.tok) begin
            if (r_mode == MODE_HUNGRY && r_age >= i_ctx.top) begin
                if (!r_busy && !i_nbr_busy) begin
                    n_mode     = MODE_EATING;
                    n_age      = '0;
                    n_ctx.top  = '0;
                    n_busy     = 1'b1;
                    n_grant    = 1'b1;
                    o_link.set = 1'b1;
                end else begin
                    if (r_age > i_ctx.top) begin
                        n_ctx.top = r_age;
                    end
                    // saturate at all ones
                    if (r_age != '1) begin
                        n_age = r_age + t_age'(1);
                    end
                end
            end else if (r_mode == MODE_DONE) begin
                n_mode     = MODE_THINKING;
                n_busy     = 1'b0;
                n_rel      = 1'b1;
                o_link.clr = 1'b1;
            end
        end
        // counterclockwise neighbor claims or frees this resource
        if (i_link.set) begin
            n_busy = 1'b1;
        end
        if (i_link.clr) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_THINKING;
            r_age     <= '0;
            r_busy    <= 1'b0;
            r_grant   <= 1'b0;
            r_rel     <= 1'b0;
            r_ctx.tok <= 1'b0;
            r_ctx.top <= '0;
        end else begin
            r_mode    <= n_mode;
            r_age     <= n_age;
            r_busy    <= n_busy;
            r_grant   <= n_grant;
            r_rel     <= n_rel;
            r_ctx.tok <= n_ctx.tok;
            r_ctx.top <= n_ctx.top;
        end
    end

    assign o_ctx  = r_ctx;
    assign o_busy = r_busy;

    always_comb begin
        o_status.grant        = r_grant;
        o_status.release_done = r_rel;
        o_status.eating       = (r_mode == MODE_EATING);
        o_status.waiting      = (r_mode == MODE_HUNGRY);
    end

    `RRA_ASSERT_NEXT(a_tok_pass, i_clk, i_rst_n, i_ctx.tok, r_ctx.tok)
    `RRA_ASSERT_IMPLY(a_grant_eats, i_clk, i_rst_n, r_grant, r_mode == MODE_EATING)
    `RRA_ASSERT_NEXT(a_done_frees, i_clk, i_rst_n, i_ctx.tok && r_mode == MODE_DONE, !r_busy)

endmodule

`default_nettype wire

// ----- design/ring_resource_arbiter_with_aging.sv -----
// Ring resource arbiter with aging: a ring of AGENTS cells scanned in order.
// A tick is taken only while idle; the scan token then passes through each cell in turn,
// the final top priority is taken from the last cell, and the results are loaded into the
// output register. A waiting result stalls the next scan in drain, and so the input, until
// it is taken.
// Reset (i_rst_n low, synchronous): agents thinking, ages, top and resources clear.
`default_nettype none
`include "ring_resource_arbiter_with_aging_assert.svh"

module ring_resource_arbiter_with_aging (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rra_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rra_pkg::t_out      o_out_data
);
    import rra_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state r_state;
    logic   r_start;
    t_age   r_top;
    logic   r_out_valid;
    t_out   r_out;

    logic    load;
    t_ctx    ctx_head;
    t_ctx    ctx     [AGENTS];
    t_link   link    [AGENTS];
    logic    busy    [AGENTS];
    t_status status  [AGENTS];
    logic [AGENTS-1:0] tok_vec;
    logic [AGENTS-1:0] grant_v, rel_v, eat_v, wait_v;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign load         = i_in_valid && o_in_ready;
    assign ctx_head.tok = r_start;
    assign ctx_head.top = r_top;

    for (genvar g = 0; g < AGENTS; g++) begin : g_cell
        logic hunger_bit, finish_bit;
        if (g < EVT_W) begin : g_evt
            assign hunger_bit = i_in_data.hunger_events[g];
            assign finish_bit = i_in_data.finish_events[g];
        end else begin : g_no_evt
            assign hunger_bit = 1'b0;
            assign finish_bit = 1'b0;
        end

        rra_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (load),
            .i_hunger   (hunger_bit),
            .i_finish   (finish_bit),
            .i_ctx      ((g == 0) ? ctx_head : ctx[(g + AGENTS - 1) % AGENTS]),
            .o_ctx      (ctx[g]),
            .i_nbr_busy (busy[(g + 1) % AGENTS]),
            .o_busy     (busy[g]),
            .i_link     (link[(g + AGENTS - 1) % AGENTS]),
            .o_link     (link[g]),
            .o_status   (status[g])
        );

        assign tok_vec[g] = ctx[g].tok;
        assign grant_v[g] = status[g].grant;
        assign rel_v[g]   = status[g].release_done;
        assign eat_v[g]   = status[g].eating;
        assign wait_v[g]  = status[g].waiting;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_start <= load;
            if (r_state == ST_DRAIN && (!r_out_valid || i_out_ready)) begin
                r_out_valid            <= 1'b1;
                r_out.grant_mask       <= EVT_W'(grant_v);
                r_out.release_mask     <= EVT_W'(rel_v);
                r_out.eating_mask      <= EVT_W'(eat_v);
                r_out.waiting_mask     <= EVT_W'(wait_v);
                r_out.top_priority_out <= PRIO_W'(r_top);
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (load) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // token leaves the last cell: scan complete
                    if (ctx[AGENTS-1].tok) begin
                        r_top   <= ctx[AGENTS-1].top;
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RRA_ASSERT_IMPLY(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(tok_vec))
    `RRA_ASSERT_IMPLY(a_idle_no_token, i_clk, i_rst_n, o_in_ready, tok_vec == '0)
    `RRA_ASSERT_IMPLY(a_grant_not_release, i_clk, i_rst_n, o_out_valid,
                      (o_out_data.grant_mask & o_out_data.release_mask) == '0)

endmodule

`default_nettype wire

// ----- tb/sv/ring_resource_arbiter_with_aging_checker.sv -----
// Scoreboard for the ring resource arbiter: watches both channels, runs its own
// scan of the agent ring for every accepted tick and compares the results in order.
// Depends on rra_pkg for the item types, the agent count and the mode encoding.
`timescale 1ns / 100ps

module ring_resource_arbiter_with_aging_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ready,
    input  wire rra_pkg::t_in  i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  wire rra_pkg::t_out i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import rra_pkg::*;

    t_mode agent_mode_q [AGENTS];
    t_age  agent_age_q  [AGENTS];
    logic  res_busy_q   [AGENTS];
    t_age  top_prio_q;

    t_out  scan_results_q [$];
    t_out  want;
    t_out  got;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // One arbitration tick: take in the events, then scan the ring from agent 0.
    task automatic scan_ring(input t_in evt, output t_out res);
        int nxt;
        logic [EVT_W-1:0] grants;
        logic [EVT_W-1:0] releases;
        logic [EVT_W-1:0] eating;
        logic [EVT_W-1:0] waiting;
        grants   = '0;
        releases = '0;
        eating   = '0;
        waiting  = '0;
        for (int i = 0; i < AGENTS; i++) begin
            if (agent_mode_q[i] == MODE_THINKING && evt.hunger_events[i]) begin
                agent_mode_q[i] = MODE_HUNGRY;
            end else if (agent_mode_q[i] == MODE_EATING && evt.finish_events[i]) begin
                agent_mode_q[i] = MODE_DONE;
            end
        end
        for (int i = 0; i < AGENTS; i++) begin
            nxt = (i + 1) % AGENTS;
            if (agent_mode_q[i] == MODE_HUNGRY && agent_age_q[i] >= top_prio_q) begin
                if (!res_busy_q[i] && !res_busy_q[nxt]) begin
                    res_busy_q[i]   = 1'b1;
                    res_busy_q[nxt] = 1'b1;
                    agent_mode_q[i] = MODE_EATING;
                    agent_age_q[i]  = '0;
                    top_prio_q      = '0;
                    grants[i]       = 1'b1;
                end else begin
                    if (agent_age_q[i] > top_prio_q) begin
                        top_prio_q = agent_age_q[i];
                    end
                    // saturate, never wrap
                    if (agent_age_q[i] != '1) begin
                        agent_age_q[i] = agent_age_q[i] + t_age'(1);
                    end
                end
            end else if (agent_mode_q[i] == MODE_DONE) begin
                res_busy_q[i]   = 1'b0;
                res_busy_q[nxt] = 1'b0;
                agent_mode_q[i] = MODE_THINKING;
                releases[i]     = 1'b1;
            end
        end
        for (int i = 0; i < AGENTS; i++) begin
            eating[i]  = (agent_mode_q[i] == MODE_EATING);
            waiting[i] = (agent_mode_q[i] == MODE_HUNGRY);
        end
        res.grant_mask       = grants;
        res.release_mask     = releases;
        res.eating_mask      = eating;
        res.waiting_mask     = waiting;
        res.top_priority_out = PRIO_W'(top_prio_q);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AGENTS; i++) begin
                agent_mode_q[i] = MODE_THINKING;
                agent_age_q[i]  = '0;
                res_busy_q[i]   = 1'b0;
            end
            top_prio_q = '0;
            scan_results_q.delete();
        end else begin
            // compare before predicting: a result never belongs to the tick taken this edge
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (scan_results_q.size() == 0) begin
                    $error("result item with no tick outstanding: 0x%0h", got);
                    o_fail_count++;
                end else begin
                    want = scan_results_q.pop_front();
                    check_field("grant_mask", 32'(want.grant_mask), 32'(got.grant_mask));
                    check_field("release_mask", 32'(want.release_mask),
                                32'(got.release_mask));
                    check_field("eating_mask", 32'(want.eating_mask), 32'(got.eating_mask));
                    check_field("waiting_mask", 32'(want.waiting_mask),
                                32'(got.waiting_mask));
                    check_field("top_priority_out", 32'(want.top_priority_out),
                                32'(got.top_priority_out));
                end
            end
            if (i_in_valid && i_in_ready) begin
                scan_ring(i_in_data, want);
                scan_results_q.push_back(want);
            end
        end
        o_pending = scan_results_q.size();
    end

endmodule

// ----- tb/sv/ring_resource_arbiter_with_aging_tb.sv -----
// Testbench top for the ring resource arbiter: clock, reset, tick stimulus,
// output back-pressure, watchdog and verdict. Checking lives in the checker module.
// Depends on rra_pkg, the arbiter RTL and ring_resource_arbiter_with_aging_checker.
`timescale 1ns / 100ps

module ring_resource_arbiter_with_aging_tb;
    import rra_pkg::*;

    localparam int SCAN_LATENCY   = AGENTS + 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int AGE_FILL_TICKS = 40;
    localparam int PHASE_TICKS    = 270;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic in_valid   = 1'b0;
    t_in  in_data    = '0;
    logic out_ready  = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    int   fail_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off_req   = 1'b0;
    logic hold_off_done  = 1'b0;
    int   hold_off_cnt   = 0;
    int   quiet_cycles   = 0;

    always #5 i_clk = ~i_clk;

    ring_resource_arbiter_with_aging DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    ring_resource_arbiter_with_aging_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus one long hold-off so the input backs up.
    always @(posedge i_clk) begin
        if (hold_off_req && !hold_off_done) begin
            out_ready <= 1'b0;
            hold_off_cnt++;
            if (hold_off_cnt >= HOLD_OFF_LEN) begin
                hold_off_done = 1'b1;
            end
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[ring_resource_arbiter_with_aging] ERROR");
            $finish;
        end
    end

    task automatic offer_tick(input logic [EVT_W-1:0] hunger, input logic [EVT_W-1:0] finish);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_data.hunger_events <= hunger;
        in_data.finish_events <= finish;
        in_valid              <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Mix dense traffic with sparse finishes so agents pile up and age.
    task automatic offer_random_tick();
        logic [EVT_W-1:0] hunger;
        logic [EVT_W-1:0] finish;
        hunger = EVT_W'($urandom);
        finish = EVT_W'($urandom);
        case ($urandom_range(0, 3))
            0: finish = finish & EVT_W'($urandom) & EVT_W'($urandom);
            1: finish = '0;
            2: hunger = hunger & EVT_W'($urandom);
            default: ;
        endcase
        offer_tick(hunger, finish);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Long wait: agent 1 eats and holds on, agent 0 waits on it and ages.
        offer_tick(5'b00010, 5'b00000);
        offer_tick(5'b00001, 5'b00000);
        repeat (AGE_FILL_TICKS) offer_tick('0, '0);
        offer_tick(5'b00000, 5'b00010);
        offer_tick(5'b00000, 5'b00000);
        offer_tick(5'b00000, 5'b00001);

        // Directed: extremes, contention and aging, both events on one agent,
        // release then grant in the same scan, a hungry agent younger than top,
        // events in the wrong mode.
        offer_tick(5'b00000, 5'b00000);
        offer_tick(5'b11111, 5'b00000);
        offer_tick(5'b00000, 5'b00000);
        offer_tick(5'b00000, 5'b00000);
        offer_tick(5'b11111, 5'b11111);
        offer_tick(5'b00000, 5'b01000);
        offer_tick(5'b00101, 5'b00000);
        offer_tick(5'b00000, 5'b00000);
        offer_tick(5'b01000, 5'b00000);
        offer_tick(5'b00000, 5'b10010);
        offer_tick(5'b00000, 5'b00000);
        offer_tick(5'b11111, 5'b00101);
        offer_tick(5'b00000, 5'b11111);
        offer_tick(5'b11111, 5'b11111);
        offer_tick(5'b10101, 5'b01010);
        offer_tick(5'b01010, 5'b10101);
        offer_tick(5'b00000, 5'b11111);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            repeat (PHASE_TICKS) offer_random_tick();
        end

        // Back-pressure: hold the result side off while ticks keep coming.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req  <= 1'b1;
        repeat (120) offer_random_tick();

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2 * SCAN_LATENCY) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ring_resource_arbiter_with_aging] OK");
        end else begin
            $display("[ring_resource_arbiter_with_aging] ERROR");
        end
        $finish;
    end

endmodule
